// ===== rtl/cfdm_pkg.sv =====
`default_nettype none

package cfdm_pkg;

   // fixed field widths
   localparam int FREQ_W     = 32;
   localparam int DUTY_W     = 7;
   localparam int PROD_W     = 39;
   localparam int STATUS_W   = 2;
   localparam int STEP_CNT_W = 5;

   // divider step counts (one quotient bit per cycle)
   localparam int FREQ_STEPS = 32;
   localparam int DUTY_STEPS = 7;

   localparam int DUTY_SCALE = 100;
   localparam logic [31:0] NUMERATOR_RESET = 32'd256000000;

   // request opcodes
   localparam logic OP_CAPTURE  = 1'b0;
   localparam logic OP_OVERFLOW = 1'b1;

   // edge to arm next
   localparam logic EDGE_RISING  = 1'b0;
   localparam logic EDGE_FALLING = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_PERIOD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVF_SAT     = 2'd2;

   // measurement phase
   typedef enum logic [1:0] {
      PH_RISE  = 2'd0,
      PH_FALL  = 2'd1,
      PH_CLOSE = 2'd2
   } cfdm_phase_type;

   // sequencer state
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_FREQ,
      ST_DUTY_LOAD,
      ST_DUTY,
      ST_DONE
   } cfdm_state_type;

   // divider commands
   typedef struct packed {
      logic load;
      logic step;
      logic probe;
   } cfdm_div_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/cfdm_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per step. The compare/subtract is
// also borrowed for a plain a >= divisor check in probe mode.
module cfdm_div #(
   parameter int DW = 32
) (
   input  wire                          clock,
   input  wire cfdm_pkg::cfdm_div_ctrl_type ctrl,
   input  wire  [DW-1:0]                load_rem,
   input  wire  [cfdm_pkg::FREQ_W-1:0]  load_dvd,
   input  wire  [DW-1:0]                divisor,
   input  wire  [DW:0]                  probe_a,
   output logic [cfdm_pkg::FREQ_W-1:0]  quotient,
   output logic                         ge
);

   logic [DW-1:0]               rem_ff, rem_in;
   logic [cfdm_pkg::FREQ_W-1:0] dvd_ff, dvd_in;
   logic [cfdm_pkg::FREQ_W-1:0] quo_ff, quo_in;
   logic [DW:0]                 trial;
   logic [DW+1:0]               diff;

   // shared compare/subtract
   assign trial = ctrl.probe ? probe_a : {rem_ff, dvd_ff[cfdm_pkg::FREQ_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor};
   assign ge    = ~diff[DW+1];

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         rem_in = load_rem;
         dvd_in = load_dvd;
         quo_in = '0;
      end else if (ctrl.step) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         dvd_in = {dvd_ff[cfdm_pkg::FREQ_W-2:0], 1'b0};
         quo_in = {quo_ff[cfdm_pkg::FREQ_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/capture_frequency_duty_meter.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_opcode, req_capture_stamp
// rsp       out        rsp_valid/rsp_ready  rsp_next_edge, rsp_measurement_valid,
//                                           rsp_frequency, rsp_duty_percent, rsp_status
// csr       in         csr_write_enable     csr_write_data (frequency numerator)
//
// Overflow ticks give no response; other captures, and a closing one
// with zero period or saturated wraps, register their response at acceptance.
// A closing capture with a measurement takes its response from the shared 1-bit-per-cycle
// divider (setup, 32 frequency steps, duty load, 7 duty steps, result), and no request is
// taken until that response is registered. Synchronous active-high reset; no request is taken
// while a response is stalled unless it is being taken in the same cycle.
module capture_frequency_duty_meter #(
   parameter int TIMER_BITS    = 16,
   parameter int OVERFLOW_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_opcode,
   input  wire  [15:0] req_capture_stamp,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_next_edge,
   output logic        rsp_measurement_valid,
   output logic [31:0] rsp_frequency,
   output logic [6:0]  rsp_duty_percent,
   output logic [1:0]  rsp_status,
   input  wire         csr_write_enable,
   input  wire  [31:0] csr_write_data
);

   localparam int EW  = OVERFLOW_BITS + TIMER_BITS;
   localparam int EW1 = EW + 1;
   localparam int DW  = (EW > 32) ? EW : 32;
   localparam int DW1 = DW + 1;
   localparam int SW  = TIMER_BITS + 16;

   localparam int FW = cfdm_pkg::FREQ_W;
   localparam int UW = cfdm_pkg::DUTY_W;
   localparam int PW = cfdm_pkg::PROD_W;
   localparam int CW = cfdm_pkg::STEP_CNT_W;

   cfdm_pkg::cfdm_state_type state_ff, state_in;
   cfdm_pkg::cfdm_phase_type phase_ff, phase_in;

   logic [TIMER_BITS-1:0]    first_stamp_ff, first_stamp_in;
   logic [31:0]              high_ticks_ff, high_ticks_in;
   logic [OVERFLOW_BITS-1:0] ovf_cnt_ff, ovf_cnt_in;
   logic                     ovf_sat_ff, ovf_sat_in;
   logic [31:0]              numerator_ff, numerator_in;
   logic [DW-1:0]            period_ff, period_in;
   logic [PW-1:0]            prod_ff, prod_in;
   logic                     duty_sat_ff, duty_sat_in;
   logic [CW-1:0]            cnt_ff, cnt_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_next_edge_ff, rsp_next_edge_in;
   logic                         rsp_meas_ff, rsp_meas_in;
   logic [FW-1:0]                rsp_frequency_ff, rsp_frequency_in;
   logic [UW-1:0]                rsp_duty_ff, rsp_duty_in;
   logic [cfdm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                         accept;
   logic [SW-1:0]                stamp_wide;
   logic [TIMER_BITS-1:0]        stamp_t;
   logic [EW:0]                  elapsed_diff;
   logic [EW-1:0]                elapsed;
   logic [DW-1:0]                elapsed_dw;
   logic [31:0]                  high_sat;
   logic [OVERFLOW_BITS-1:0]     ovf_next;

   cfdm_pkg::cfdm_div_ctrl_type  div_ctrl;
   logic [DW-1:0]                div_load_rem;
   logic [FW-1:0]                div_load_dvd;
   logic [DW:0]                  div_probe_a;
   logic [FW-1:0]                div_quo;
   logic                         div_ge;

   // handshake
   assign req_ready = (state_ff == cfdm_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // stamp limited to the timer width
   assign stamp_wide = {{TIMER_BITS{1'b0}}, req_capture_stamp};
   assign stamp_t    = stamp_wide[TIMER_BITS-1:0];

   // elapsed ticks since the first capture, clamped at zero
   assign elapsed_diff = {1'b0, ovf_cnt_ff, stamp_t} - EW1'(first_stamp_ff);
   assign elapsed      = elapsed_diff[EW] ? '0 : elapsed_diff[EW-1:0];
   assign elapsed_dw   = DW'(elapsed);
   assign high_sat     = (elapsed_dw > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                         : elapsed_dw[31:0];

   // saturating wrap counter
   assign ovf_next = (ovf_cnt_ff == {OVERFLOW_BITS{1'b1}}) ? ovf_cnt_ff
                                                         : ovf_cnt_ff + 1'b1;

   assign div_probe_a = DW1'(high_ticks_ff);

   cfdm_div #(
      .DW(DW)
   ) u_div (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .load_rem (div_load_rem),
      .load_dvd (div_load_dvd),
      .divisor  (period_ff),
      .probe_a  (div_probe_a),
      .quotient (div_quo),
      .ge       (div_ge)
   );

   // sequencer: next state and datapath controls
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      first_stamp_in   = first_stamp_ff;
      high_ticks_in    = high_ticks_ff;
      ovf_cnt_in       = ovf_cnt_ff;
      ovf_sat_in       = ovf_sat_ff;
      numerator_in     = csr_write_enable ? csr_write_data : numerator_ff;
      period_in        = period_ff;
      prod_in          = prod_ff;
      duty_sat_in      = duty_sat_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_next_edge_in = rsp_next_edge_ff;
      rsp_meas_in      = rsp_meas_ff;
      rsp_frequency_in = rsp_frequency_ff;
      rsp_duty_in      = rsp_duty_ff;
      rsp_status_in    = rsp_status_ff;
      div_ctrl         = '0;
      div_load_rem     = '0;
      div_load_dvd     = '0;

      case (state_ff)
         cfdm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == cfdm_pkg::OP_OVERFLOW) begin
                  // wraps count only inside a measurement
                  if (phase_ff == cfdm_pkg::PH_FALL || phase_ff == cfdm_pkg::PH_CLOSE) begin
                     ovf_cnt_in = ovf_next;
                     ovf_sat_in = ovf_sat_ff || (ovf_next == {OVERFLOW_BITS{1'b1}});
                  end
               end else begin
                  rsp_valid_in     = 1'b1;
                  rsp_next_edge_in = cfdm_pkg::EDGE_RISING;
                  rsp_meas_in      = 1'b0;
                  rsp_frequency_in = '0;
                  rsp_duty_in      = '0;
                  rsp_status_in    = cfdm_pkg::STATUS_OK;
                  case (phase_ff)
                     cfdm_pkg::PH_FALL: begin
                        high_ticks_in = high_sat;
                        phase_in      = cfdm_pkg::PH_CLOSE;
                     end
                     cfdm_pkg::PH_CLOSE: begin
                        phase_in  = cfdm_pkg::PH_RISE;
                        period_in = elapsed_dw;
                        if (ovf_sat_ff) begin
                           rsp_status_in = cfdm_pkg::STATUS_OVF_SAT;
                        end else if (elapsed == '0) begin
                           rsp_status_in = cfdm_pkg::STATUS_ZERO_PERIOD;
                        end else begin
                           // response comes from the divider
                           rsp_valid_in = 1'b0;
                           state_in     = cfdm_pkg::ST_PREP;
                        end
                     end
                     default: begin
                        first_stamp_in   = stamp_t;
                        ovf_cnt_in       = '0;
                        ovf_sat_in       = 1'b0;
                        phase_in         = cfdm_pkg::PH_FALL;
                        rsp_next_edge_in = cfdm_pkg::EDGE_FALLING;
                     end
                  endcase
               end
            end
         end

         cfdm_pkg::ST_PREP: begin
            // duty clips at 100 exactly when high >= period
            div_ctrl.probe = 1'b1;
            div_ctrl.load  = 1'b1;
            div_load_rem   = '0;
            div_load_dvd   = numerator_ff;
            duty_sat_in    = div_ge;
            prod_in        = PW'(high_ticks_ff) * PW'(cfdm_pkg::DUTY_SCALE);
            cnt_in         = CW'(cfdm_pkg::FREQ_STEPS - 1);
            state_in       = cfdm_pkg::ST_FREQ;
         end

         cfdm_pkg::ST_FREQ: begin
            div_ctrl.step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = cfdm_pkg::ST_DUTY_LOAD;
            end
         end

         cfdm_pkg::ST_DUTY_LOAD: begin
            // quotient below 128, so the top bits start as the remainder
            rsp_frequency_in = div_quo;
            div_ctrl.load    = 1'b1;
            div_load_rem     = DW'(prod_ff[PW-1:UW]);
            div_load_dvd     = {prod_ff[UW-1:0], {(FW-UW){1'b0}}};
            cnt_in           = CW'(cfdm_pkg::DUTY_STEPS - 1);
            state_in         = cfdm_pkg::ST_DUTY;
         end

         cfdm_pkg::ST_DUTY: begin
            div_ctrl.step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = cfdm_pkg::ST_DONE;
            end
         end

         cfdm_pkg::ST_DONE: begin
            rsp_valid_in     = 1'b1;
            rsp_next_edge_in = cfdm_pkg::EDGE_RISING;
            rsp_meas_in      = 1'b1;
            rsp_duty_in      = duty_sat_ff ? UW'(cfdm_pkg::DUTY_SCALE) : div_quo[UW-1:0];
            rsp_status_in    = cfdm_pkg::STATUS_OK;
            state_in         = cfdm_pkg::ST_IDLE;
         end

         default: begin
            state_in = cfdm_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfdm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cfdm_pkg::PH_RISE;
         ovf_cnt_ff   <= '0;
         ovf_sat_ff   <= 1'b0;
         numerator_ff <= cfdm_pkg::NUMERATOR_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ovf_cnt_ff   <= ovf_cnt_in;
         ovf_sat_ff   <= ovf_sat_in;
         numerator_ff <= numerator_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_stamp_ff   <= first_stamp_in;
      high_ticks_ff    <= high_ticks_in;
      period_ff        <= period_in;
      prod_ff          <= prod_in;
      duty_sat_ff      <= duty_sat_in;
      rsp_next_edge_ff <= rsp_next_edge_in;
      rsp_meas_ff      <= rsp_meas_in;
      rsp_frequency_ff <= rsp_frequency_in;
      rsp_duty_ff      <= rsp_duty_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_next_edge         = rsp_next_edge_ff;
   assign rsp_measurement_valid = rsp_meas_ff;
   assign rsp_frequency         = rsp_frequency_ff;
   assign rsp_duty_percent      = rsp_duty_ff;
   assign rsp_status            = rsp_status_ff;

   // checks
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == cfdm_pkg::ST_DONE |=> rsp_valid_ff)
      else $error("finished measurement did not reach the response register");

   a_meas_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_meas_ff) |->
         (rsp_status_ff == cfdm_pkg::STATUS_OK && rsp_duty_ff <= UW'(cfdm_pkg::DUTY_SCALE)))
      else $error("valid measurement with bad status or duty");

   a_sat_at_max: assert property (@(posedge clock) disable iff (reset)
      ovf_sat_ff |-> ovf_cnt_ff == {OVERFLOW_BITS{1'b1}})
      else $error("saturation flag set below the counter maximum");

   a_fall_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == cfdm_pkg::OP_CAPTURE && phase_ff == cfdm_pkg::PH_FALL)
         |=> (rsp_valid_ff && phase_ff == cfdm_pkg::PH_CLOSE))
      else $error("falling-edge capture gave no response");

endmodule

`default_nettype wire

// ===== tb/cfdm_meter_checker.sv =====
`default_nettype none

// Watches both channels of the meter, keeps its own copy of the measurement
// state, and compares every accepted response with the oldest prediction.
module cfdm_meter_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire         req_opcode,
   input  wire  [15:0] req_capture_stamp,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire         rsp_next_edge,
   input  wire         rsp_measurement_valid,
   input  wire  [31:0] rsp_frequency,
   input  wire  [6:0]  rsp_duty_percent,
   input  wire  [1:0]  rsp_status,
   input  wire         csr_write_enable,
   input  wire  [31:0] csr_write_data,
   output int          error_count,
   output int          pending_results
);

   localparam logic [15:0] WRAP_MAX = 16'hFFFF;

   typedef struct packed {
      logic        next_edge;
      logic        meas_valid;
      logic [31:0] frequency;
      logic [6:0]  duty;
      logic [1:0]  status;
   } meter_reading_type;

   meter_reading_type expected_readings[$];
   meter_reading_type oldest_reading;

   // local copy of the measurement state
   cfdm_pkg::cfdm_phase_type edge_phase;
   logic [15:0]    start_stamp;
   logic [31:0]    high_time;
   logic [15:0]    wrap_count;
   logic           wrap_saturated;
   logic [31:0]    numerator;
   int             mismatches = 0;

   // ticks since the opening edge, wraps included; clamped at zero
   function automatic logic [63:0] ticks_since_start(input logic [15:0] stamp);
      logic [63:0] total;
      total = ({48'd0, wrap_count} << 16) + {48'd0, stamp};
      if (total >= {48'd0, start_stamp})
         return total - {48'd0, start_stamp};
      return 64'd0;
   endfunction

   // advance the measurement state by one request, queue any reading it gives
   task automatic predict_reading(input logic op, input logic [15:0] stamp);
      meter_reading_type reading;
      logic [63:0]    elapsed;
      logic [63:0]    quotient;
      reading = '0;
      if (op == cfdm_pkg::OP_OVERFLOW) begin
         // wraps only count once the opening edge has been seen
         if (edge_phase == cfdm_pkg::PH_FALL || edge_phase == cfdm_pkg::PH_CLOSE) begin
            if (wrap_count == WRAP_MAX) begin
               wrap_saturated = 1'b1;
            end else begin
               wrap_count = wrap_count + 16'd1;
               if (wrap_count == WRAP_MAX)
                  wrap_saturated = 1'b1;
            end
         end
      end else begin
         elapsed = ticks_since_start(stamp);
         case (edge_phase)
            cfdm_pkg::PH_FALL: begin
               high_time = (elapsed > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : elapsed[31:0];
               edge_phase = cfdm_pkg::PH_CLOSE;
               reading.next_edge = cfdm_pkg::EDGE_RISING;
            end
            cfdm_pkg::PH_CLOSE: begin
               // saturated wrap count wins over a zero period
               if (wrap_saturated) begin
                  reading.status = cfdm_pkg::STATUS_OVF_SAT;
               end else if (elapsed == 64'd0) begin
                  reading.status = cfdm_pkg::STATUS_ZERO_PERIOD;
               end else begin
                  reading.status = cfdm_pkg::STATUS_OK;
                  reading.meas_valid = 1'b1;
                  quotient = {32'd0, numerator} / elapsed;
                  reading.frequency = quotient[31:0];
                  quotient = ({32'd0, high_time} * cfdm_pkg::DUTY_SCALE) / elapsed;
                  reading.duty = (quotient > cfdm_pkg::DUTY_SCALE)
                                 ? cfdm_pkg::DUTY_W'(cfdm_pkg::DUTY_SCALE)
                                 : quotient[6:0];
               end
               edge_phase = cfdm_pkg::PH_RISE;
               reading.next_edge = cfdm_pkg::EDGE_RISING;
            end
            default: begin
               // opening edge; an unused phase value behaves the same
               start_stamp = stamp;
               wrap_count = 16'd0;
               wrap_saturated = 1'b0;
               edge_phase = cfdm_pkg::PH_FALL;
               reading.next_edge = cfdm_pkg::EDGE_FALLING;
            end
         endcase
         expected_readings.push_back(reading);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         edge_phase = cfdm_pkg::PH_RISE;
         start_stamp = '0;
         high_time = '0;
         wrap_count = '0;
         wrap_saturated = 1'b0;
         numerator = cfdm_pkg::NUMERATOR_RESET;
         expected_readings.delete();
      end else begin
         if (csr_write_enable)
            numerator = csr_write_data;
         // responses first: none can belong to a request taken on this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: response with nothing outstanding, expected none, %s",
                        $time, "actual");
               $display("   %0d/%0d/%0d/%0d/%0d", rsp_next_edge, rsp_measurement_valid,
                        rsp_frequency, rsp_duty_percent, rsp_status);
               mismatches++;
            end else begin
               oldest_reading = expected_readings.pop_front();
               check_field("next_edge", 32'(oldest_reading.next_edge), 32'(rsp_next_edge));
               check_field("measurement_valid", 32'(oldest_reading.meas_valid),
                           32'(rsp_measurement_valid));
               check_field("frequency", oldest_reading.frequency, rsp_frequency);
               check_field("duty_percent", 32'(oldest_reading.duty), 32'(rsp_duty_percent));
               check_field("status", 32'(oldest_reading.status), 32'(rsp_status));
            end
         end
         if (req_valid && req_ready)
            predict_reading(req_opcode, req_capture_stamp);
      end
      error_count <= mismatches;
      pending_results <= expected_readings.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          SETTLE_CYCLES = 60;
   localparam logic [15:0] STAMP_MAX     = 16'hFFFF;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [15:0] req_capture_stamp;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_next_edge;
   logic        rsp_measurement_valid;
   logic [31:0] rsp_frequency;
   logic [6:0]  rsp_duty_percent;
   logic [1:0]  rsp_status;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   int error_count;
   int pending_results;
   int cycle_count = 0;
   int items_sent = 0;
   int capture_phase = 0;
   bit allow_gaps = 1'b1;

   capture_frequency_duty_meter u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_capture_stamp     (req_capture_stamp),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_next_edge         (rsp_next_edge),
      .rsp_measurement_valid (rsp_measurement_valid),
      .rsp_frequency         (rsp_frequency),
      .rsp_duty_percent      (rsp_duty_percent),
      .rsp_status            (rsp_status),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   cfdm_meter_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_capture_stamp     (req_capture_stamp),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_next_edge         (rsp_next_edge),
      .rsp_measurement_valid (rsp_measurement_valid),
      .rsp_frequency         (rsp_frequency),
      .rsp_duty_percent      (rsp_duty_percent),
      .rsp_status            (rsp_status),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .error_count           (error_count),
      .pending_results       (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly short idle spells, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // distance between edges: often tiny, so short periods and high rates appear
   function automatic logic [15:0] pick_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 16'($urandom_range(0, 3));
      if (roll < 60) return 16'($urandom_range(0, 255));
      return 16'($urandom);
   endfunction

   function automatic int pick_wraps();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return 1;
      if (roll < 98) return $urandom_range(2, 5);
      return $urandom_range(6, 40);
   endfunction

   // result-side back-pressure: stalls of random length between ready spells
   initial begin : rsp_ready_driver
      int hold;
      int spell;
      rsp_ready = 1'b0;
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ready <= 1'b1;
         spell = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         repeat (spell - 1) @(negedge clock);
      end
   end

   // present one request and hold it until it is taken
   task automatic send_request(input logic op, input logic [15:0] stamp);
      int gap;
      gap = allow_gaps ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_capture_stamp <= stamp;
      do @(posedge clock); while (!req_ready);
      // wrap ticks before the opening edge are dropped by the block
      if (!(op == cfdm_pkg::OP_OVERFLOW && capture_phase == 0))
         items_sent++;
      if (op == cfdm_pkg::OP_CAPTURE)
         capture_phase = (capture_phase == 2) ? 0 : capture_phase + 1;
   endtask

   task automatic send_wraps(input int count);
      repeat (count) send_request(cfdm_pkg::OP_OVERFLOW, 16'($urandom));
   endtask

   // stop sending and let every outstanding response drain
   task automatic wait_all_results();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_numerator(input logic [31:0] value);
      wait_all_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   // rising, falling, rising with random stamps and wraps in between
   task automatic send_measurement();
      logic [15:0] rise_stamp;
      logic [15:0] fall_stamp;
      logic [15:0] close_stamp;
      // finish off any sequence left open by stray captures
      while (capture_phase != 0)
         send_request(cfdm_pkg::OP_CAPTURE, 16'($urandom));
      rise_stamp = 16'($urandom);
      fall_stamp = rise_stamp + pick_span();
      close_stamp = fall_stamp + pick_span();
      send_request(cfdm_pkg::OP_CAPTURE, rise_stamp);
      send_wraps(pick_wraps());
      send_request(cfdm_pkg::OP_CAPTURE, fall_stamp);
      send_wraps(pick_wraps());
      send_request(cfdm_pkg::OP_CAPTURE, close_stamp);
   endtask

   task automatic run_random_phase(input int quota);
      int stop_at;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         allow_gaps = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 9) < 8)
            send_measurement();
         else
            send_request(1'($urandom_range(0, 1)), 16'($urandom));
         // occasionally hold off until the block has answered everything
         if ($urandom_range(0, 39) == 0)
            wait_all_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = cfdm_pkg::OP_CAPTURE;
      req_capture_stamp = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed, on the reset numerator
      send_request(cfdm_pkg::OP_OVERFLOW, STAMP_MAX);   // wrap while idle is dropped
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0000);
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0001);
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0002);
      // zero period
      send_request(cfdm_pkg::OP_CAPTURE, STAMP_MAX);
      send_request(cfdm_pkg::OP_CAPTURE, STAMP_MAX);
      send_request(cfdm_pkg::OP_CAPTURE, STAMP_MAX);
      // falling stamp before the opening one clamps the high time to zero
      send_request(cfdm_pkg::OP_CAPTURE, 16'h1000);
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0800);
      send_request(cfdm_pkg::OP_OVERFLOW, 16'h0000);
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0000);
      // high time longer than the period: duty clips
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0000);
      send_request(cfdm_pkg::OP_CAPTURE, 16'hF000);
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0010);
      // wraps inside both halves
      send_request(cfdm_pkg::OP_CAPTURE, STAMP_MAX);
      send_request(cfdm_pkg::OP_OVERFLOW, 16'h0000);
      send_request(cfdm_pkg::OP_CAPTURE, 16'h0000);
      send_request(cfdm_pkg::OP_OVERFLOW, 16'h0000);
      send_request(cfdm_pkg::OP_OVERFLOW, 16'h0000);
      send_request(cfdm_pkg::OP_CAPTURE, STAMP_MAX);

      // random phases across numerator settings
      write_numerator(32'd1);
      run_random_phase(140);
      write_numerator(32'hFFFF_FFFF);
      run_random_phase(140);
      write_numerator(32'($urandom));
      run_random_phase(140);
      write_numerator(32'($urandom_range(1, 1000)));
      run_random_phase(130);

      wait_all_results();
      if (error_count == 0 && pending_results == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/cfdm_pkg.sv
rtl/cfdm_div.sv
rtl/capture_frequency_duty_meter.sv
tb/cfdm_meter_checker.sv
tb/tb_top.sv
